>>> rtl/core/hfsl_pkg.sv
// Package for the hierarchical fair-share lock policy engine.
// Holds transaction structs, operation codes and default constants; no dependencies.
`default_nettype none

package hfsl_pkg;

  localparam int unsigned NodeCountDef   = 16;
  localparam int unsigned ThreadCountDef = 16;
  localparam int unsigned DepthDef       = 4;
  localparam int unsigned NodeWgtW       = 21;
  localparam int unsigned ThrWgtW        = 17;
  localparam logic [31:0] GranReset      = 32'd1000000;

  typedef enum logic [1:0] {
    OP_DEFINE   = 2'd0,
    OP_REGISTER = 2'd1,
    OP_ACQUIRE  = 2'd2,
    OP_RELEASE  = 2'd3
  } hfsl_op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  thread_id;
    logic [3:0]  node_id;
    logic [3:0]  parent_node;
    logic [16:0] weight;
    logic [63:0] now;
  } hfsl_in_t;

  typedef struct packed {
    logic        granted;
    logic        reentered;
    logic        banned;
    logic [63:0] time_value;
  } hfsl_out_t;

  // Classified transaction handed from the front to the back
  typedef struct packed {
    hfsl_op_e op;
    logic     thr_ok;
    logic     node_ok;
    hfsl_in_t item;
  } hfsl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/hfsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hfsl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/hfsl_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end.
// Depends on hfsl_pkg.
`default_nettype none

module hfsl_front #(
  parameter int unsigned NODE_COUNT   = 16,
  parameter int unsigned THREAD_COUNT = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire hfsl_pkg::hfsl_in_t item_i,
  output logic                    busy,
  output logic                    cmd_vld_o,
  output hfsl_pkg::hfsl_cmd_t     cmd_o,
  input  wire logic               cmd_pop_i
);
  import hfsl_pkg::*;

  hfsl_cmd_t   fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;
  hfsl_cmd_t   cls;

  // Classify the incoming transaction
  always_comb begin
    cls.op      = hfsl_op_e'(item_i.operation);
    cls.thr_ok  = (32'(item_i.thread_id) < THREAD_COUNT);
    cls.node_ok = (32'(item_i.node_id) < NODE_COUNT);
    cls.item    = item_i;
  end

  assign busy      = (cnt_q == 2'd2);
  assign push      = start && !busy;
  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = fifo_q[rd_ptr_q];

  // Hold queued transactions
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hfsl_mdu.sv
// Serial unit: 21-bit quotient num/den (zero when den is zero), then times a 64-bit factor.
// One bit per cycle for both steps; no dependencies.
`default_nettype none

module hfsl_mdu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [20:0] num_i,
  input  wire logic [20:0] den_i,
  input  wire logic [63:0] mult_i,
  output logic             done_o,
  output logic [63:0]      prod_o
);

  typedef enum logic [1:0] {
    P_IDLE,
    P_DIV,
    P_MUL
  } phase_e;

  phase_e      phase_q;
  logic [4:0]  cnt_q;
  logic [20:0] rem_q, quo_q, den_q;
  logic [63:0] mc_q, acc_q;
  logic        done_q;
  logic [21:0] shifted;

  assign shifted = {rem_q, quo_q[20]};

  // Restoring division then shift-add multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= 5'd0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        P_IDLE: begin
          if (start_i) begin
            rem_q   <= '0;
            den_q   <= den_i;
            mc_q    <= mult_i;
            acc_q   <= '0;
            cnt_q   <= 5'd20;
            quo_q   <= (den_i == '0) ? '0 : num_i;
            phase_q <= (den_i == '0) ? P_MUL : P_DIV;
          end
        end
        P_DIV: begin
          if (shifted >= {1'b0, den_q}) begin
            rem_q <= 21'(shifted - {1'b0, den_q});
            quo_q <= {quo_q[19:0], 1'b1};
          end else begin
            rem_q <= shifted[20:0];
            quo_q <= {quo_q[19:0], 1'b0};
          end
          if (cnt_q == 5'd0) begin
            cnt_q   <= 5'd20;
            phase_q <= P_MUL;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        P_MUL: begin
          if (quo_q[0]) begin
            acc_q <= acc_q + mc_q;
          end
          mc_q  <= {mc_q[62:0], 1'b0};
          quo_q <= {1'b0, quo_q[20:1]};
          if (cnt_q == 5'd0) begin
            done_q  <= 1'b1;
            phase_q <= P_IDLE;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

>>> rtl/core/hfsl_back.sv
// Back end: sequencer that walks the node path and carries out each transaction.
// Depends on hfsl_pkg, hfsl_ram and hfsl_mdu.
`default_nettype none

module hfsl_back #(
  parameter int unsigned NODE_COUNT   = 16,
  parameter int unsigned THREAD_COUNT = 16,
  parameter int unsigned DEPTH        = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [31:0]         gran_i,
  input  wire logic                cmd_vld_i,
  input  wire hfsl_pkg::hfsl_cmd_t cmd_i,
  output logic                     cmd_pop_o,
  output logic                     done_o,
  output hfsl_pkg::hfsl_out_t      res_o
);
  import hfsl_pkg::*;

  localparam int unsigned NW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned TW  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int unsigned PW  = $clog2(DEPTH + 2);
  localparam int unsigned IW  = (DEPTH > 0) ? $clog2(DEPTH + 1) : 1;
  localparam int unsigned NWW = NW + NodeWgtW + 128;
  localparam int unsigned TWW = NW + ThrWgtW + 193;

  typedef enum logic [3:0] {
    S_IDLE, S_ZERO, S_DEF, S_THR, S_PATH, S_PATH_W, S_N_RD, S_N_LAT,
    S_N_OP, S_N_MD, S_ACQ_DEC, S_REL_T, S_REL_W, S_FIN
  } state_e;

  function automatic logic [NW-1:0] nidx(input logic [3:0] v);
    return (32'(v) < NODE_COUNT) ? NW'(v) : '0;
  endfunction

  state_e            state_q;
  hfsl_op_e          op_q;
  hfsl_in_t          item_q;
  hfsl_out_t         res_q;
  logic              done_q;

  logic [NW-1:0]     chain_q [DEPTH+1];
  logic [PW-1:0]     n_q;
  logic [IW-1:0]     idx_q;
  logic [NW-1:0]     p_q;
  logic              pass2_q, reacq_q;
  logic [63:0]       ban_acc_q, m_q, cs_q, pmax_q;

  logic [NW-1:0]     th_home_q;
  logic [16:0]       th_w_q;
  logic [63:0]       th_ban_q, th_slice_q, th_start_q;
  logic              th_flag_q;

  logic [NW-1:0]     nd_par_q;
  logic [20:0]       nd_w_q;
  logic [63:0]       nd_ban_q, nd_slice_q;

  logic [20:0]       total_q;
  logic [63:0]       lock_end_q;
  logic              lock_vld_q;

  logic [NODE_COUNT-1:0]   node_vld_q;
  logic [THREAD_COUNT-1:0] thr_vld_q;
  logic              nrd_vld_q, trd_vld_q;

  logic              node_we, thr_we;
  logic [NW-1:0]     node_waddr, node_raddr;
  logic [TW-1:0]     thr_addr;
  logic [NWW-1:0]    node_wdata, node_rdata, nrd;
  logic [TWW-1:0]    thr_wdata, thr_rdata, trd;

  logic              mdu_start, mdu_done;
  logic [20:0]       mdu_den;
  logic [63:0]       mdu_prod;

  logic [NW-1:0]     nrd_par;
  logic [20:0]       nrd_w;
  logic [63:0]       nrd_ban, nrd_slice;
  logic [NW-1:0]     trd_home;
  logic [16:0]       trd_w;
  logic [63:0]       trd_ban, trd_slice, trd_start;
  logic              trd_flag;

  logic              is_root, reent_hit;
  logic [63:0]       now, acq_sl, rel_ban, rel_b, ban_mx;

  assign now = item_q.now;

  // Unpack read data; entries never written read as zero
  assign nrd = nrd_vld_q ? node_rdata : '0;
  assign trd = trd_vld_q ? thr_rdata : '0;
  assign {nrd_par, nrd_w, nrd_ban, nrd_slice} = nrd;
  assign {trd_home, trd_w, trd_ban, trd_slice, trd_start, trd_flag} = trd;

  assign is_root   = ((PW'(idx_q) + PW'(1)) == n_q);
  assign reent_hit = lock_vld_q && (lock_end_q == trd_slice) && (now < lock_end_q);
  assign acq_sl    = (nd_slice_q <= now) ? now + (64'(gran_i) << idx_q) : nd_slice_q;
  assign rel_ban   = nd_ban_q + mdu_prod;
  assign rel_b     = ((th_ban_q + mdu_prod) < pmax_q) ? pmax_q : th_ban_q + mdu_prod;
  assign ban_mx    = (nrd_ban > ban_acc_q) ? nrd_ban : ban_acc_q;

  assign cmd_pop_o = cmd_vld_i && (state_q == S_IDLE);

  // Memory and divider controls
  always_comb begin
    node_we    = 1'b0;
    node_waddr = chain_q[idx_q];
    node_wdata = {nd_par_q, nd_w_q, nd_ban_q, nd_slice_q};
    node_raddr = p_q;
    thr_we     = (state_q == S_FIN);
    thr_addr   = TW'(item_q.thread_id);
    thr_wdata  = {th_home_q, th_w_q, th_ban_q, th_slice_q, th_start_q, th_flag_q};
    mdu_start  = 1'b0;
    mdu_den    = nd_w_q;
    case (state_q)
      S_IDLE: begin
        node_raddr = nidx(cmd_i.item.node_id);
        thr_addr   = TW'(cmd_i.item.thread_id);
      end
      S_DEF: begin
        node_we    = 1'b1;
        node_waddr = nidx(item_q.node_id);
        node_wdata = {nidx(item_q.parent_node), nrd_w, nrd_ban, nrd_slice};
      end
      S_N_RD: node_raddr = chain_q[idx_q];
      S_N_OP: begin
        case (op_q)
          OP_REGISTER: begin
            node_we    = 1'b1;
            node_wdata = {nd_par_q, 21'(nd_w_q + 21'(item_q.weight)),
                          is_root ? nd_ban_q : now, nd_slice_q};
          end
          OP_ACQUIRE: begin
            node_we    = pass2_q;
            node_wdata = {nd_par_q, nd_w_q, nd_ban_q, acq_sl};
          end
          OP_RELEASE: mdu_start = 1'b1;
          default: ;
        endcase
      end
      S_N_MD: begin
        node_we    = mdu_done;
        node_wdata = {nd_par_q, nd_w_q, rel_ban, nd_slice_q};
      end
      S_REL_T: begin
        mdu_start = 1'b1;
        mdu_den   = 21'(th_w_q);
      end
      default: ;
    endcase
  end

  hfsl_ram #(.WIDTH(NWW), .DEPTH(NODE_COUNT), .AW(NW)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  hfsl_ram #(.WIDTH(TWW), .DEPTH(THREAD_COUNT), .AW(TW)) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .waddr_i (thr_addr),
    .wdata_i (thr_wdata),
    .raddr_i (thr_addr),
    .rdata_o (thr_rdata)
  );

  hfsl_mdu u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mdu_start),
    .num_i   (total_q),
    .den_i   (mdu_den),
    .mult_i  (cs_q),
    .done_o  (mdu_done),
    .prod_o  (mdu_prod)
  );

  // Track written entries; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_vld_q <= '0;
      thr_vld_q  <= '0;
      nrd_vld_q  <= 1'b0;
      trd_vld_q  <= 1'b0;
    end else begin
      if (node_we) begin
        node_vld_q[node_waddr] <= 1'b1;
      end
      if (thr_we) begin
        thr_vld_q[thr_addr] <= 1'b1;
      end
      nrd_vld_q <= node_vld_q[node_raddr];
      trd_vld_q <= thr_vld_q[thr_addr];
    end
  end

  // Sequencer: state, lock state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      total_q    <= '0;
      lock_end_q <= '0;
      lock_vld_q <= 1'b0;
      n_q        <= '0;
      idx_q      <= '0;
      pass2_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_vld_i) begin
            op_q   <= cmd_i.op;
            item_q <= cmd_i.item;
            res_q  <= '0;
            n_q    <= '0;
            if (cmd_i.op == OP_DEFINE) begin
              state_q <= cmd_i.node_ok ? S_DEF : S_ZERO;
            end else begin
              state_q <= cmd_i.thr_ok ? S_THR : S_ZERO;
            end
          end
        end
        S_ZERO, S_DEF: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_THR: begin
          th_home_q  <= trd_home;
          th_w_q     <= trd_w;
          th_ban_q   <= trd_ban;
          th_slice_q <= trd_slice;
          th_start_q <= trd_start;
          th_flag_q  <= trd_flag;
          p_q        <= trd_home;
          ban_acc_q  <= trd_ban;
          reacq_q    <= 1'b1;
          pass2_q    <= 1'b0;
          pmax_q     <= '0;
          cs_q       <= now - trd_start;
          state_q    <= S_PATH;
          case (op_q)
            OP_REGISTER: begin
              th_home_q  <= nidx(item_q.node_id);
              p_q        <= nidx(item_q.node_id);
              th_w_q     <= item_q.weight;
              th_ban_q   <= now;
              th_slice_q <= '0;
              th_start_q <= '0;
              th_flag_q  <= 1'b0;
            end
            OP_ACQUIRE: begin
              if (reent_hit) begin
                th_start_q <= now;
                res_q      <= '{granted: 1'b1, reentered: 1'b1, banned: trd_flag,
                                time_value: trd_slice};
                state_q    <= S_FIN;
              end
            end
            default: ;
          endcase
        end
        S_PATH: begin
          n_q <= n_q + PW'(1);
          if ((p_q != '0) && (32'(n_q) < DEPTH)) begin
            chain_q[n_q[IW-1:0]] <= p_q;
            state_q <= S_PATH_W;
          end else begin
            chain_q[n_q[IW-1:0]] <= '0;
            idx_q   <= n_q[IW-1:0];
            state_q <= S_N_RD;
          end
        end
        S_PATH_W: begin
          p_q     <= nrd_par;
          state_q <= S_PATH;
        end
        S_N_RD: state_q <= S_N_LAT;
        S_N_LAT: begin
          nd_par_q   <= nrd_par;
          nd_w_q     <= nrd_w;
          nd_ban_q   <= nrd_ban;
          nd_slice_q <= nrd_slice;
          if (op_q == OP_ACQUIRE && !pass2_q) begin
            // first pass only reads: merge ban time and check running slices
            ban_acc_q <= ban_mx;
            if (!is_root && (now > nrd_slice)) begin
              reacq_q <= 1'b0;
            end
          end
          state_q <= S_N_OP;
        end
        S_N_OP: begin
          if (op_q == OP_RELEASE) begin
            state_q <= S_N_MD;
          end else begin
            if (op_q == OP_ACQUIRE && pass2_q && (acq_sl < m_q)) begin
              m_q <= acq_sl;
            end
            if (idx_q != '0) begin
              idx_q   <= idx_q - IW'(1);
              state_q <= S_N_RD;
            end else if (op_q == OP_REGISTER) begin
              total_q <= 21'(total_q + 21'(item_q.weight));
              res_q   <= '{granted: 1'b0, reentered: 1'b0, banned: 1'b0, time_value: now};
              state_q <= S_FIN;
            end else if (!pass2_q) begin
              state_q <= S_ACQ_DEC;
            end else begin
              th_start_q <= now;
              th_slice_q <= (acq_sl < m_q) ? acq_sl : m_q;
              lock_end_q <= (acq_sl < m_q) ? acq_sl : m_q;
              lock_vld_q <= 1'b1;
              res_q      <= '{granted: 1'b1, reentered: 1'b0, banned: th_flag_q,
                              time_value: (acq_sl < m_q) ? acq_sl : m_q};
              state_q    <= S_FIN;
            end
          end
        end
        S_N_MD: begin
          if (mdu_done) begin
            if (rel_ban > pmax_q) begin
              pmax_q <= rel_ban;
            end
            if (idx_q != '0) begin
              idx_q   <= idx_q - IW'(1);
              state_q <= S_N_RD;
            end else begin
              state_q <= S_REL_T;
            end
          end
        end
        S_ACQ_DEC: begin
          if (ban_acc_q > now) begin
            th_ban_q <= ban_acc_q;
          end
          if (th_flag_q && (now < ban_acc_q)) begin
            res_q   <= '{granted: 1'b0, reentered: 1'b0, banned: 1'b1,
                         time_value: ban_acc_q};
            state_q <= S_FIN;
          end else begin
            lock_vld_q <= 1'b0;
            if (reacq_q || (ban_acc_q <= now)) begin
              pass2_q <= 1'b1;
              m_q     <= now + 64'(gran_i);
              idx_q   <= IW'(n_q - PW'(1));
              state_q <= S_N_RD;
            end else begin
              th_flag_q <= 1'b1;
              res_q     <= '{granted: 1'b0, reentered: 1'b0, banned: 1'b1,
                             time_value: ban_acc_q};
              state_q   <= S_FIN;
            end
          end
        end
        S_REL_T: state_q <= S_REL_W;
        S_REL_W: begin
          if (mdu_done) begin
            th_ban_q  <= rel_b;
            th_flag_q <= (now < rel_b);
            if (now < rel_b) begin
              lock_vld_q <= 1'b0;
            end
            res_q   <= '{granted: 1'b0, reentered: 1'b0, banned: (now < rel_b),
                         time_value: rel_b};
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTH
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobes back to back");
  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.granted |-> lock_vld_q)
    else $error("grant without open lock slice");
  a_reent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.reentered |-> res_o.granted)
    else $error("reentry without grant");
  a_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n_q) <= DEPTH + 1)
    else $error("path longer than depth");
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni) !(node_we && thr_we))
    else $error("node and thread write in one cycle");
`endif

endmodule

`default_nettype wire

>>> rtl/core/hierarchical_fair_share_lock_policy.sv
// The node path, counted with the root, is 1 to DEPTH+1 nodes long.
// Throughput: one transaction at a time in the back end; a two-entry queue takes up to two more.
// Results appear for one cycle on done_o and cannot be stalled.
// Reset clears all state at once through per-entry valid bits; no clearing pass.
// Top level: front queue, back sequencer, granularity register. Depends on hfsl_pkg, hfsl_front and hfsl_back.
`default_nettype none

module hierarchical_fair_share_lock_policy #(
  parameter int unsigned NODE_COUNT   = hfsl_pkg::NodeCountDef,
  parameter int unsigned THREAD_COUNT = hfsl_pkg::ThreadCountDef,
  parameter int unsigned DEPTH        = hfsl_pkg::DepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire hfsl_pkg::hfsl_in_t item_i,
  output logic                    busy,
  output logic                    done_o,
  output hfsl_pkg::hfsl_out_t     result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i
);
  import hfsl_pkg::*;

  logic [31:0] gran_q;
  logic        cmd_vld, cmd_pop;
  hfsl_cmd_t   cmd;

  // Hold slice granularity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gran_q <= GranReset;
    end else if (cfg_we_i) begin
      gran_q <= cfg_wdata_i;
    end
  end

  hfsl_front #(.NODE_COUNT(NODE_COUNT), .THREAD_COUNT(THREAD_COUNT)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .item_i    (item_i),
    .busy      (busy),
    .cmd_vld_o (cmd_vld),
    .cmd_o     (cmd),
    .cmd_pop_i (cmd_pop)
  );

  hfsl_back #(.NODE_COUNT(NODE_COUNT), .THREAD_COUNT(THREAD_COUNT), .DEPTH(DEPTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gran_i    (gran_q),
    .cmd_vld_i (cmd_vld),
    .cmd_i     (cmd),
    .cmd_pop_o (cmd_pop),
    .done_o    (done_o),
    .res_o     (result_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the hierarchical fair-share lock policy engine.
// Drives define/register/acquire/release transactions and checks every result
// against its own copy of the accounting state. Depends on hfsl_pkg and the top level.
`timescale 1ns / 1ps

module tb_top;
  import hfsl_pkg::*;

  localparam int unsigned NODES   = 16;
  localparam int unsigned THREADS = 16;
  localparam int unsigned LEVELS  = 4;
  localparam int unsigned ITEMS   = 1050;

  // Lock accounting predictor and queue of pending lock results
  class lock_scoreboard;
    logic [31:0]  gran;
    logic [3:0]   nd_parent[NODES];
    logic [20:0]  nd_weight[NODES];
    logic [63:0]  nd_ban[NODES];
    logic [63:0]  nd_slice[NODES];
    logic [3:0]   th_home[THREADS];
    logic [16:0]  th_weight[THREADS];
    logic [63:0]  th_ban[THREADS];
    logic [63:0]  th_slice[THREADS];
    logic [63:0]  th_start[THREADS];
    logic         th_flag[THREADS];
    logic [20:0]  total_wgt;
    logic [63:0]  lock_end;
    logic         lock_live;
    logic [3:0]   walk[LEVELS+1];
    hfsl_out_t    pending[$];
    int           mismatches;
    int           checked;
    int           grants;

    function new();
      gran = GranReset;
      total_wgt = '0;
      lock_end = '0;
      lock_live = 1'b0;
      mismatches = 0;
      checked = 0;
      grants = 0;
      for (int i = 0; i < NODES; i++) begin
        nd_parent[i] = '0;
        nd_weight[i] = '0;
        nd_ban[i] = '0;
        nd_slice[i] = '0;
      end
      for (int i = 0; i < THREADS; i++) begin
        th_home[i] = '0;
        th_weight[i] = '0;
        th_ban[i] = '0;
        th_slice[i] = '0;
        th_start[i] = '0;
        th_flag[i] = 1'b0;
      end
    endfunction

    function void set_gran(logic [31:0] v);
      gran = v;
    endfunction

    // Fill walk[] from root down to home; return path length
    function int trace_path(logic [3:0] home);
      logic [3:0] chain[LEVELS+1];
      int n;
      logic [3:0] p;
      n = 0;
      p = home;
      while (p != 0 && n < LEVELS) begin
        chain[n] = p;
        n++;
        p = nd_parent[p];
      end
      chain[n] = 0;
      n++;
      for (int i = 0; i < n; i++) walk[i] = chain[n-1-i];
      return n;
    endfunction

    function logic [63:0] share(logic [20:0] num, logic [20:0] den);
      return (den == 0) ? 64'd0 : 64'(num / den);
    endfunction

    // Compute the result of one accepted transaction and queue it
    function void note(hfsl_in_t it);
      hfsl_out_t r;
      int n;
      logic [3:0] t;
      logic [3:0] k;
      logic [63:0] now, ban, m, cs, pmax, b;
      bit reacq;
      r = '0;
      t = it.thread_id;
      now = it.now;
      case (hfsl_op_e'(it.operation))
        OP_DEFINE: begin
          nd_parent[it.node_id] = it.parent_node;
          pending.push_back(r);
          return;
        end
        OP_REGISTER: begin
          th_home[t] = it.node_id;
          th_weight[t] = it.weight;
          th_ban[t] = now;
          th_slice[t] = '0;
          th_start[t] = '0;
          th_flag[t] = 1'b0;
          total_wgt = total_wgt + 21'(it.weight);
          nd_weight[0] = nd_weight[0] + 21'(it.weight);
          n = trace_path(it.node_id);
          for (int i = 1; i < n; i++) begin
            nd_weight[walk[i]] = nd_weight[walk[i]] + 21'(it.weight);
            nd_ban[walk[i]] = now;
          end
          r.time_value = now;
        end
        OP_ACQUIRE: begin
          n = trace_path(th_home[t]);
          if (lock_live && lock_end == th_slice[t] && now < lock_end) begin
            // Re-enter the running slice
            th_start[t] = now;
            r.granted = 1'b1;
            r.reentered = 1'b1;
            r.time_value = th_slice[t];
          end else begin
            ban = th_ban[t];
            for (int i = 0; i < n; i++)
              if (nd_ban[walk[i]] > ban) ban = nd_ban[walk[i]];
            if (ban > now) th_ban[t] = ban;
            if (th_flag[t] && now < ban) begin
              r.time_value = ban;
            end else begin
              reacq = 1'b1;
              lock_live = 1'b0;
              for (int i = 1; i < n; i++)
                if (now > nd_slice[walk[i]]) reacq = 1'b0;
              if (reacq || ban <= now) begin
                // Open slices that halve from root toward the leaf
                m = now + 64'(gran);
                for (int i = 0; i < n; i++) begin
                  k = walk[i];
                  if (nd_slice[k] <= now) nd_slice[k] = now + (64'(gran) << (n - 1 - i));
                  if (nd_slice[k] < m) m = nd_slice[k];
                end
                th_start[t] = now;
                th_slice[t] = m;
                lock_end = m;
                lock_live = 1'b1;
                r.granted = 1'b1;
                r.time_value = m;
              end else begin
                th_flag[t] = 1'b1;
                r.time_value = ban;
              end
            end
          end
        end
        default: begin
          // Charge hold time to the whole path and the thread
          cs = now - th_start[t];
          pmax = '0;
          n = trace_path(th_home[t]);
          for (int i = 0; i < n; i++) begin
            k = walk[i];
            nd_ban[k] = nd_ban[k] + cs * share(total_wgt, nd_weight[k]);
            if (nd_ban[k] > pmax) pmax = nd_ban[k];
          end
          b = th_ban[t] + cs * share(total_wgt, 21'(th_weight[t]));
          if (pmax > b) b = pmax;
          th_ban[t] = b;
          th_flag[t] = (now < b);
          if (th_flag[t]) lock_live = 1'b0;
          r.time_value = b;
        end
      endcase
      r.banned = th_flag[t];
      if (r.granted) grants++;
      pending.push_back(r);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", what, want, got);
    endfunction

    // Compare one result with the oldest pending one
    function void check(hfsl_out_t got);
      hfsl_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.granted !== want.granted) report("granted", 64'(want.granted), 64'(got.granted));
      if (got.reentered !== want.reentered)
        report("reentered", 64'(want.reentered), 64'(got.reentered));
      if (got.banned !== want.banned) report("banned", 64'(want.banned), 64'(got.banned));
      if (got.time_value !== want.time_value)
        report("time_value", want.time_value, got.time_value);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  hfsl_in_t    item;
  logic        busy;
  logic        done;
  hfsl_out_t   result;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  lock_scoreboard sb;
  logic [15:0]    registered;
  logic [63:0]    clock_now;
  int             sent;
  int             burst_left;

  hierarchical_fair_share_lock_policy i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .item_i     (item),
    .busy       (busy),
    .done_o     (done),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Check every result strobe
  always @(posedge clk) begin
    if (rst_n && done) sb.check(result);
  end

  function automatic hfsl_in_t mk(hfsl_op_e op, int tid, int nid, int par, int w,
                                  logic [63:0] now);
    hfsl_in_t it;
    it.operation = op;
    it.thread_id = 4'(tid);
    it.node_id = 4'(nid);
    it.parent_node = 4'(par);
    it.weight = 17'(w);
    it.now = now;
    return it;
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send(hfsl_in_t it);
    @(negedge clk);
    start = 1'b1;
    item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note(it);
    if (hfsl_op_e'(it.operation) == OP_REGISTER) registered[it.thread_id] = 1'b1;
    sent++;
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Drain all results, let the back end settle, then write the granularity
  task automatic reconfigure(logic [31:0] v);
    pause(1);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (320) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    sb.set_gran(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Pick a random transaction; mostly acquire/release traffic on live threads
  function automatic hfsl_in_t pick(logic [31:0] g);
    int sel;
    int tid;
    logic [63:0] now;
    sel = $urandom_range(0, 99);
    tid = $urandom_range(0, THREADS - 1);
    if ($urandom_range(0, 19) == 0) clock_now = {$urandom, $urandom};
    else if ($urandom_range(0, 9) == 0) clock_now = clock_now - $urandom_range(0, 5000);
    else clock_now = clock_now + 64'($urandom_range(0, 3)) * g / 2 + $urandom_range(0, 99);
    now = clock_now;
    if (sel < 8)
      return mk(OP_DEFINE, tid, $urandom_range(0, 15), $urandom_range(0, 15), $urandom, now);
    if (sel < 18 || !registered[tid])
      return mk(OP_REGISTER, tid, $urandom_range(0, 15), $urandom,
                $urandom_range(1, 131071), now);
    if (sel < 62)
      return mk(OP_ACQUIRE, tid, $urandom, $urandom, $urandom, now);
    return mk(OP_RELEASE, tid, $urandom, $urandom, $urandom, now);
  endfunction

  initial begin
    logic [31:0] grans[4];
    logic [63:0] top;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    registered = '0;
    sent = 0;
    clock_now = '0;
    top = '1;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: deep and looping trees, weight extremes, re-entry, ban, root home
    send(mk(OP_DEFINE, 0, 1, 0, 0, 0));
    send(mk(OP_DEFINE, 0, 2, 1, 0, 0));
    send(mk(OP_DEFINE, 0, 3, 2, 0, 0));
    send(mk(OP_DEFINE, 0, 4, 3, 0, 0));
    send(mk(OP_DEFINE, 0, 5, 4, 0, 0));
    send(mk(OP_DEFINE, 0, 15, 15, 0, 0));
    send(mk(OP_REGISTER, 0, 5, 0, 1, 0));
    send(mk(OP_REGISTER, 15, 0, 0, 131071, 0));
    send(mk(OP_REGISTER, 1, 2, 0, 131071, 5));
    send(mk(OP_ACQUIRE, 0, 0, 0, 0, 10));
    send(mk(OP_ACQUIRE, 0, 0, 0, 0, 20));
    send(mk(OP_ACQUIRE, 1, 0, 0, 0, 30));
    send(mk(OP_RELEASE, 1, 0, 0, 0, 5000));
    send(mk(OP_ACQUIRE, 0, 0, 0, 0, 6000));
    send(mk(OP_ACQUIRE, 0, 0, 0, 0, 6001));
    send(mk(OP_RELEASE, 0, 0, 0, 0, 1000000));
    send(mk(OP_ACQUIRE, 15, 0, 0, 0, 1000001));
    send(mk(OP_REGISTER, 0, 5, 0, 131071, 1000002));
    send(mk(OP_REGISTER, 3, 15, 0, 77, 1000003));
    send(mk(OP_ACQUIRE, 3, 0, 0, 0, 1000004));
    send(mk(OP_RELEASE, 3, 0, 0, 0, top));
    send(mk(OP_ACQUIRE, 3, 0, 0, 0, 0));
    send(mk(OP_RELEASE, 15, 0, 0, 0, top));
    send(mk(OP_ACQUIRE, 1, 0, 0, 0, top));

    // Random phases, each with its own granularity
    grans[0] = 32'd1;
    grans[1] = 32'hFFFF_FFFF;
    grans[2] = GranReset;
    grans[3] = $urandom_range(1, 5000);
    for (int ph = 0; ph < 4; ph++) begin
      reconfigure(grans[ph]);
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < ITEMS / 4; i++) begin
        send(pick(grans[ph]));
        burst_left--;
        if (burst_left == 0) begin
          pause($urandom_range(0, 30));
          burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
      end
    end

    // Drain and settle
    pause(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("sent %0d transactions over 4 granularity settings; %0d results, %0d grants",
             sent, sb.checked, sb.grants);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_top failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #60000000;
    $display("timeout");
    $display("tb_top failed");
    $finish;
  end

endmodule

>>> hierarchical_fair_share_lock_policy.f
rtl/core/hfsl_pkg.sv
rtl/core/hfsl_ram.sv
rtl/core/hfsl_front.sv
rtl/core/hfsl_mdu.sv
rtl/core/hfsl_back.sv
rtl/core/hierarchical_fair_share_lock_policy.sv
tb/tb_top.sv
